>>> rtl/gact_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and helpers for the gyro air cursor tracker
// no dependencies; imported by every module of the block

package gact_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SENS_W      = 16;
  localparam int LIMIT_W     = 8;
  localparam int CNT_W       = 8;
  localparam int CURSOR_W    = 16;
  localparam int POS_FRAC    = 8;
  localparam int POS_W       = CURSOR_W + POS_FRAC;
  localparam int PROD_W      = SAMPLE_BITS + SENS_W + 1;
  localparam int DIFF_W      = PROD_W + 1;
  localparam int CODE_W      = 2;

  localparam int IN_DATA_BITS  = 2 * SAMPLE_BITS + 2 * CURSOR_W;
  localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = 2 * CURSOR_W + 2 * CODE_W;
  localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_DATA_BITS;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = SENS_W;

  localparam logic [SENS_W-1:0]  SENS_RESET  = SENS_W'(256);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

  localparam logic signed [DIFF_W-1:0] POS_MAX_EXT = DIFF_W'((2 ** (POS_W - 1)) - 1);
  localparam logic signed [DIFF_W-1:0] POS_MIN_EXT = ~POS_MAX_EXT;

  localparam logic [CODE_W-1:0] CODE_IDLE = 2'd0;
  localparam logic [CODE_W-1:0] CODE_NEG  = 2'd1;
  localparam logic [CODE_W-1:0] CODE_POS  = 2'd2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SENSITIVITY    = 1'b0,
    REG_REVERSAL_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MOT_IDLE = 3'b001,
    MOT_NEG  = 3'b010,
    MOT_POS  = 3'b100
  } motion_t;

  typedef struct packed {
    logic take;
    logic adv;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [CURSOR_W-1:0] cursor;
    logic [CODE_W-1:0]          motion;
  } lane_res_t;

  function automatic logic [CODE_W-1:0] motion_code(input motion_t m);
    logic [CODE_W-1:0] code;
    case (m)
      MOT_NEG: code = CODE_NEG;
      MOT_POS: code = CODE_POS;
      default: code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/gact_lane.sv
`timescale 1ns / 1ps
// one axis tracker lane: motion state, reversal counter, gain multiply and position
// depends on gact_pkg

module gact_lane (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  gact_pkg::lane_ctl_t                     ctl,
  input  logic                                    load_cmd,
  input  logic signed [gact_pkg::SAMPLE_BITS-1:0] sample,
  input  logic signed [gact_pkg::CURSOR_W-1:0]    load_pos,
  input  logic [gact_pkg::SENS_W-1:0]             sens,
  input  logic [gact_pkg::LIMIT_W-1:0]            rev_limit,
  output gact_pkg::lane_res_t                     res
);
  import gact_pkg::*;

  motion_t                   mot_r, mot_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_r;
  logic signed [POS_W-1:0]   pos_r, pos_nxt;

  // stage one registers
  logic                      act_r;
  logic                      load_r;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [CURSOR_W-1:0] load_val_r;
  motion_t                   mot_out_r;

  motion_t                   mot_a, mot_b;
  logic [CNT_W-1:0]          cnt_inc;
  logic                      s_neg, s_pos;
  logic signed [DIFF_W-1:0]  diff;

  assign s_neg   = sample[SAMPLE_BITS-1];
  assign s_pos   = (sample != '0) && !sample[SAMPLE_BITS-1];
  assign cnt_inc = (cnt_r == {CNT_W{1'b1}}) ? cnt_r : cnt_r + CNT_W'(1);

  always_comb begin
    mot_a   = (sample == '0) ? MOT_IDLE : mot_r;
    mot_b   = mot_a;
    cnt_nxt = cnt_r;
    case (mot_a)
      MOT_NEG: begin
        cnt_nxt = (sample > prev_r) ? cnt_inc : '0;
      end
      MOT_POS: begin
        cnt_nxt = (sample < prev_r) ? cnt_inc : '0;
      end
      default: begin
        cnt_nxt = '0;
        if (s_neg && sample <= prev_r) begin
          mot_b = MOT_NEG;
        end else if (s_pos && sample >= prev_r) begin
          mot_b = MOT_POS;
        end else begin
          mot_b = MOT_IDLE;
        end
      end
    endcase
    mot_nxt = (cnt_nxt > rev_limit) ? MOT_IDLE : mot_b;
  end

  assign prod_nxt = PROD_W'(sample) * PROD_W'($signed({1'b0, sens}));

  // position load, or update with saturation
  assign diff = {{(DIFF_W - POS_W){pos_r[POS_W-1]}}, pos_r} - {prod_r[PROD_W-1], prod_r};

  always_comb begin
    pos_nxt = pos_r;
    if (load_r) begin
      pos_nxt = {load_val_r, {POS_FRAC{1'b0}}};
    end else if (act_r) begin
      if (diff > POS_MAX_EXT) begin
        pos_nxt = POS_MAX_EXT[POS_W-1:0];
      end else if (diff < POS_MIN_EXT) begin
        pos_nxt = POS_MIN_EXT[POS_W-1:0];
      end else begin
        pos_nxt = diff[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mot_r  <= MOT_IDLE;
      cnt_r  <= '0;
      prev_r <= '0;
      pos_r  <= '0;
      act_r  <= 1'b0;
      load_r <= 1'b0;
    end else begin
      if (ctl.take) begin
        if (load_cmd) begin
          load_r <= 1'b1;
          act_r  <= 1'b0;
        end else begin
          mot_r  <= mot_nxt;
          cnt_r  <= cnt_nxt;
          prev_r <= sample;
          load_r <= 1'b0;
          act_r  <= (mot_nxt != MOT_IDLE);
        end
      end
      if (ctl.adv) begin
        pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      prod_r     <= prod_nxt;
      load_val_r <= load_pos;
      mot_out_r  <= load_cmd ? mot_r : mot_nxt;
    end
  end

  assign res.cursor = pos_nxt[POS_W-1:POS_FRAC];
  assign res.motion = motion_code(mot_out_r);

endmodule

>>> rtl/gact_merge.sv
`timescale 1ns / 1ps
// merges both lane results into the registered result channel
// depends on gact_pkg

module gact_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  gact_pkg::lane_res_t                horiz,
  input  gact_pkg::lane_res_t                vert,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [gact_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import gact_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [OUT_TDATA_W-1:0] data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= {{OUT_PAD_W{1'b0}}, vert.motion, horiz.motion, vert.cursor, horiz.cursor};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

>>> rtl/gyro_air_cursor_tracker.sv
`timescale 1ns / 1ps
// top level of the gyro air cursor tracker: config registers, handshake, two axis lanes
// depends on gact_pkg, gact_lane, gact_merge

// Takes one transfer per clock and returns one result per transfer once the result side
// is ready: a lane stage registers the motion update and the sample times gain product,
// then the position accumulate and saturate feeds the output register. The sustained
// rate is one item per cycle; the input stalls only while both the lane stage and the
// output register hold results not yet taken.
// Gyro X drives the vertical axis, gyro Z the horizontal one; tuser = 1 loads the cursor.

module gyro_air_cursor_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [gact_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [gact_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // gyro_x_rate, gyro_z_rate, load_x, load_y
  input  logic [gact_pkg::IN_TDATA_W-1:0]   in_tdata,
  // cmd
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // cursor_x, cursor_y, horiz_state, vert_state, zero pad
  output logic [gact_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import gact_pkg::*;

  logic [SENS_W-1:0]  sens_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               s1_v_r, s1_v_nxt;
  logic               out_free;
  lane_ctl_t          ctl;
  lane_res_t          horiz_res, vert_res;

  logic signed [SAMPLE_BITS-1:0] gyro_x, gyro_z;
  logic signed [CURSOR_W-1:0]    load_x, load_y;

  assign gyro_x = in_tdata[SAMPLE_BITS-1:0];
  assign gyro_z = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign load_x = in_tdata[2*SAMPLE_BITS+CURSOR_W-1:2*SAMPLE_BITS];
  assign load_y = in_tdata[2*SAMPLE_BITS+2*CURSOR_W-1:2*SAMPLE_BITS+CURSOR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r  <= SENS_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SENSITIVITY:    sens_r  <= cfg_wdata;
        REG_REVERSAL_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free  = !out_tvalid || out_tready;
  assign ctl.adv   = s1_v_r && out_free;
  assign in_tready = !s1_v_r || out_free;
  assign ctl.take  = in_tvalid && in_tready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (ctl.take) begin
      s1_v_nxt = 1'b1;
    end else if (ctl.adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  gact_lane u_vert (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .load_cmd  (in_tuser),
    .sample    (gyro_x),
    .load_pos  (load_y),
    .sens      (sens_r),
    .rev_limit (limit_r),
    .res       (vert_res)
  );

  gact_lane u_horiz (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .load_cmd  (in_tuser),
    .sample    (gyro_z),
    .load_pos  (load_x),
    .sens      (sens_r),
    .rev_limit (limit_r),
    .res       (horiz_res)
  );

  gact_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (ctl.adv),
    .horiz      (horiz_res),
    .vert       (vert_res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while lane stage and output are both full");

  a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_v_r)
    else $error("accepted item missing from lane stage");

  a_stage_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && (!out_tvalid || out_tready)) |=> out_tvalid)
    else $error("lane stage result did not reach the output register");

endmodule
